### hdl/hdbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdbt_pkg
// Shared types, constants and the CORDIC arctangent table of the home
// distance and bearing tracker.
// ----------------------------------------------------------------------------
package hdbt_pkg;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned STEP_W       = $clog2(CORDIC_STEPS);
  localparam int unsigned CW           = 44;  // CORDIC x/y datapath, signed
  localparam int unsigned ZW           = 34;  // CORDIC angle, deg*1e7, signed
  localparam int unsigned MSPLIT       = 22;  // split point of wide products

  localparam int unsigned QDEPTH = 2;         // front to back queue
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam int unsigned DIST_W = 26;

  localparam logic signed [CW-1:0] K_Q30   = 44'sd652032874;
  localparam logic signed [CW-1:0] COS_ONE = 44'sd1073741824;
  localparam logic [19:0]          K_Q20   = 20'd636752;
  localparam logic signed [ZW-1:0] DEG90   = 34'sd900000000;
  localparam logic signed [ZW-1:0] DEG180  = 34'sd1800000000;
  localparam logic [20:0]          M_PER_E8 = 21'd1113195;

  localparam logic [63:0] DIST_HALF = 64'd12800000000;
  localparam logic [63:0] DIST_SAT  = 64'd1280000025600000000;
  localparam logic [63:0] MAG_HALF  = 64'd524288;

  // distance divide: 25.6e9 = 2^16 * 390625, reciprocal underestimates by
  // at most one, fixed up by a back-multiply
  localparam logic [18:0] DIST_ODD = 19'd390625;
  localparam logic [26:0] DIST_RCP = 27'd90071992;   // floor(2^45 / 390625)
  // degree divide: 1e7 = 2^7 * 78125, exact for the angle range
  localparam logic [25:0] DEG_RCP  = 26'd56294996;   // ceil(2^42 / 78125)
  // arrow divide by 90, exact below 2048
  localparam logic [11:0] ARW_RCP  = 12'd2913;       // ceil(2^18 / 90)

  localparam logic [DIST_W-1:0] DIST_MAX = 26'd50000000;

  typedef struct packed {
    logic               clear;
    logic               fix_ok;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [27:0] alt;
    logic [8:0]         hdg;
  } item_t;

  typedef struct packed {
    logic              home_valid;
    logic [DIST_W-1:0] dist_m;
    logic [4:0]        arrow;
    logic signed [27:0] alt;
  } result_t;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_COS, S_COSW, S_MXL, S_MXH, S_VSET, S_VEC, S_VECW,
    S_MGL, S_MGH, S_DSL, S_DSH, S_DSAT, S_DQL, S_DQH, S_DFIX,
    S_ASET, S_ADIV, S_AFIX, S_RDIV, S_OUT
  } back_state_e;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 34'sd450000000;
      5'd1:    v = 34'sd265650512;
      5'd2:    v = 34'sd140362435;
      5'd3:    v = 34'sd71250163;
      5'd4:    v = 34'sd35763344;
      5'd5:    v = 34'sd17899106;
      5'd6:    v = 34'sd8951737;
      5'd7:    v = 34'sd4476142;
      5'd8:    v = 34'sd2238105;
      5'd9:    v = 34'sd1119057;
      5'd10:   v = 34'sd559529;
      5'd11:   v = 34'sd279765;
      5'd12:   v = 34'sd139882;
      5'd13:   v = 34'sd69941;
      5'd14:   v = 34'sd34971;
      5'd15:   v = 34'sd17485;
      5'd16:   v = 34'sd8743;
      5'd17:   v = 34'sd4371;
      5'd18:   v = 34'sd2186;
      5'd19:   v = 34'sd1093;
      5'd20:   v = 34'sd546;
      5'd21:   v = 34'sd273;
      5'd22:   v = 34'sd137;
      5'd23:   v = 34'sd68;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/hdbt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdbt_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module hdbt_front import hdbt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               kind_i,
  input  logic [2:0]         fix_type_i,
  input  logic signed [30:0] lat_e7_i,
  input  logic signed [31:0] lon_e7_i,
  input  logic signed [27:0] alt_cm_i,
  input  logic [8:0]         heading_deg_i,
  output logic               item_valid_o,
  output item_t              item_o,
  input  logic               item_take_i
);

  item_t             slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  item_t             dec;
  logic              push_ok, take_ok;

  always_comb begin
    dec.clear  = kind_i;
    dec.fix_ok = (fix_type_i > 3'd1);
    dec.lat    = lat_e7_i;
    dec.lon    = lon_e7_i;
    dec.alt    = alt_cm_i;
    dec.hdg    = (heading_deg_i >= 9'd360) ? heading_deg_i - 9'd360 : heading_deg_i;
  end

  assign full         = (count_q == (QPTR_W+1)'(QDEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push_ok      = push && !full;
  assign take_ok      = item_take_i && item_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (take_ok) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_ok && !take_ok) begin
        count_q <= count_q + 1'b1;
      end else if (take_ok && !push_ok) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

endmodule
`default_nettype wire

### hdl/hdbt_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdbt_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module hdbt_cordic import hdbt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cordic_req_t          req_i,
  input  logic signed [CW-1:0] x0_i,
  input  logic signed [CW-1:0] y0_i,
  input  logic signed [ZW-1:0] z0_i,
  output logic                 done_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [ZW-1:0] z_o
);

  logic signed [CW-1:0] x_q, y_q, x_d, y_d, sx, sy;
  logic signed [ZW-1:0] z_q, z_d, at;
  logic [STEP_W-1:0]    cnt_q;
  logic                 busy_q, done_q, rotate_q, sigma;

  always_comb begin
    sx = y_q >>> cnt_q;
    sy = x_q >>> cnt_q;
    at = atan_lut(cnt_q);
    // rotation drives z to zero, vectoring drives y to zero
    sigma = rotate_q ? !z_q[ZW-1] : y_q[CW-1];
    if (sigma) begin
      x_d = x_q - sx;
      y_d = y_q + sy;
      z_d = z_q - at;
    end else begin
      x_d = x_q + sx;
      y_d = y_q - sy;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(CORDIC_STEPS-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q      <= x0_i;
      y_q      <= y0_i;
      z_q      <= z0_i;
      rotate_q <= req_i.rotate;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

endmodule
`default_nettype wire

### hdl/hdbt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdbt_back
// Home state and the sequencer that computes distance and arrow per tracking request.
// ----------------------------------------------------------------------------
module hdbt_back import hdbt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_take_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_ready_i
);

  back_state_e state_q, state_d;

  logic               home_set_q;
  logic signed [30:0] home_lat_q;
  logic signed [31:0] home_lon_q;
  logic signed [27:0] home_alt_q;
  logic [DIST_W-1:0]  dist_q;
  logic [4:0]         arrow_q;

  logic [8:0]           hdg_q;
  logic signed [31:0]   dlat_q;
  logic signed [32:0]   dlon_q;
  logic [30:0]          cos_q;
  logic signed [63:0]   prod_q;
  logic signed [CW-1:0] vx_q, vy_q, xf_q;
  logic signed [ZW-1:0] vz_q, exact_q, zf_q;
  logic                 use_exact_q, neg_q;
  logic [CW-1:0]        mag_q;
  logic [63:0]          acc_q, rem_q;
  logic [DIST_W-1:0]    quo_q;
  logic signed [10:0]   whole_q;

  // CORDIC hookup
  cordic_req_t          cor_req;
  logic signed [CW-1:0] cor_x0, cor_y0, cor_x;
  logic signed [ZW-1:0] cor_z0, cor_z;
  logic                 cor_done;

  hdbt_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .x0_i   (cor_x0),
    .y0_i   (cor_y0),
    .z0_i   (cor_z0),
    .done_o (cor_done),
    .x_o    (cor_x),
    .z_o    (cor_z)
  );

  logic signed [31:0]   hl, alat;
  logic signed [ZW-1:0] alat_z, z_cos;
  logic signed [48:0]   pp_lo;
  logic signed [49:0]   pp_hi;
  logic signed [CW-1:0] xv, yv;
  logic [41:0]          mg_lo;
  logic [40:0]          mg_hi;
  logic [63:0]          mg_sum;
  logic [42:0]          ds_lo, ds_hi;
  logic [44:0]          dn, dq_back, dq_rem;
  logic [48:0]          dq_lo;
  logic [49:0]          dq_hi;
  logic [71:0]          dq_sum;
  logic                 dq_up;
  logic [50:0]          aq_prod;
  logic [22:0]          rq_prod;
  logic signed [ZW:0]   av, av_mag;
  logic signed [11:0]   w1, w2, w3, anum, hdg_s;
  logic [5:0]           arw;
  logic [10:0]          wq;

  always_comb begin
    hl     = 32'(home_lat_q);
    alat   = hl[31] ? -hl : hl;
    alat_z = ZW'(alat);
    z_cos  = (alat_z > DEG90) ? DEG90 : alat_z;

    pp_lo = dlon_q * $signed({1'b0, cos_q[14:0]});
    pp_hi = dlon_q * $signed({1'b0, cos_q[30:15]});

    xv = CW'(-(prod_q >>> 22));
    yv = CW'(dlat_q) <<< 8;

    mg_lo  = xf_q[MSPLIT-1:0] * K_Q20;
    mg_hi  = xf_q[CW-2:MSPLIT] * K_Q20;
    mg_sum = acc_q + (64'(mg_hi) << MSPLIT);
    ds_lo  = mag_q[MSPLIT-1:0] * M_PER_E8;
    ds_hi  = mag_q[CW-1:MSPLIT] * M_PER_E8;

    // distance quotient: strip 2^16, multiply by the reciprocal of the odd
    // part in two halves, then one back-multiply to round up by one
    dn      = rem_q[60:16];
    dq_lo   = dn[MSPLIT-1:0] * DIST_RCP;
    dq_hi   = dn[44:MSPLIT] * DIST_RCP;
    dq_sum  = 72'(acc_q) + (72'(dq_hi) << MSPLIT);
    dq_back = quo_q * DIST_ODD;
    dq_rem  = dn - dq_back;
    dq_up   = (dq_rem >= 45'(DIST_ODD));

    av      = (ZW+1)'(DEG90) + (ZW+1)'(zf_q);
    av_mag  = av[ZW] ? -av : av;
    // whole degrees of |angle|, truncated
    aq_prod = rem_q[31:7] * DEG_RCP;
    wq      = {2'b00, aq_prod[50:42]};

    hdg_s = $signed({3'b000, hdg_q});
    w1 = 12'(whole_q);
    if (w1 < 0) begin
      w1 = w1 + 12'sd360;
    end
    w2 = w1 - 12'sd180;
    if (w2 < 0) begin
      w2 = w2 + 12'sd360;
    end
    w3 = w2 - hdg_s;
    if (w3 < 0) begin
      w3 = w3 + 12'sd360;
    end
    anum = (w3 <<< 2) + 12'sd45;
    // anum / 90
    rq_prod = rem_q[10:0] * ARW_RCP;
    arw     = {1'b0, rq_prod[22:18]} + 6'd1;
  end

  always_comb begin
    state_d        = state_q;
    item_take_o    = 1'b0;
    res_valid_o    = 1'b0;
    cor_req.start  = 1'b0;
    cor_req.rotate = (state_q == S_COS);
    cor_x0         = (state_q == S_COS) ? K_Q30 : vx_q;
    cor_y0         = (state_q == S_COS) ? '0 : vy_q;
    cor_z0         = (state_q == S_COS) ? z_cos : vz_q;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          state_d = (item_i.clear || !home_set_q) ? S_OUT : S_COS;
        end
      end
      S_COS: begin
        cor_req.start = 1'b1;
        state_d = S_COSW;
      end
      S_COSW:  if (cor_done) state_d = S_MXL;
      S_MXL:   state_d = S_MXH;
      S_MXH:   state_d = S_VSET;
      S_VSET:  state_d = S_VEC;
      S_VEC: begin
        cor_req.start = 1'b1;
        state_d = S_VECW;
      end
      S_VECW:  if (cor_done) state_d = S_MGL;
      S_MGL:   state_d = S_MGH;
      S_MGH:   state_d = S_DSL;
      S_DSL:   state_d = S_DSH;
      S_DSH:   state_d = S_DSAT;
      S_DSAT:  state_d = (acc_q >= DIST_SAT) ? S_ASET : S_DQL;
      S_DQL:   state_d = S_DQH;
      S_DQH:   state_d = S_DFIX;
      S_DFIX:  state_d = S_ASET;
      S_ASET:  state_d = S_ADIV;
      S_ADIV:  state_d = S_AFIX;
      S_AFIX:  state_d = S_RDIV;
      S_RDIV:  state_d = S_OUT;
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      home_set_q <= 1'b0;
      home_lat_q <= '0;
      home_lon_q <= '0;
      home_alt_q <= '0;
      dist_q     <= '0;
      arrow_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            if (item_i.clear) begin
              home_set_q <= 1'b0;
              dist_q     <= '0;
              arrow_q    <= '0;
            end else if (!home_set_q && item_i.fix_ok) begin
              home_set_q <= 1'b1;
              home_lat_q <= item_i.lat;
              home_lon_q <= item_i.lon;
              home_alt_q <= item_i.alt;
            end
          end
        end
        S_DSAT:  if (acc_q >= DIST_SAT) dist_q <= DIST_MAX;
        S_DFIX:  dist_q <= dq_up ? quo_q + 1'b1 : quo_q;
        S_RDIV:  arrow_q <= (arw > 6'd16) ? 5'd0 : arw[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        hdg_q  <= item_i.hdg;
        dlat_q <= 32'(home_lat_q) - 32'(item_i.lat);
        dlon_q <= 33'(home_lon_q) - 33'(item_i.lon);
      end
      S_COSW: begin
        if (cor_x[CW-1]) begin
          cos_q <= '0;
        end else if (cor_x > COS_ONE) begin
          cos_q <= COS_ONE[30:0];
        end else begin
          cos_q <= cor_x[30:0];
        end
      end
      S_MXL: prod_q <= 64'(pp_lo);
      S_MXH: prod_q <= prod_q + (64'(pp_hi) <<< 15);
      S_VSET: begin
        use_exact_q <= (xv == '0) || (yv == '0);
        if (yv == '0) begin
          exact_q <= xv[CW-1] ? DEG180 : '0;
        end else begin
          exact_q <= yv[CW-1] ? -DEG90 : DEG90;
        end
        // left half plane: turn by 180 first
        if (xv[CW-1]) begin
          vx_q <= -xv;
          vy_q <= -yv;
          vz_q <= yv[CW-1] ? -DEG180 : DEG180;
        end else begin
          vx_q <= xv;
          vy_q <= yv;
          vz_q <= '0;
        end
      end
      S_VECW: begin
        xf_q <= cor_x[CW-1] ? '0 : cor_x;
        zf_q <= use_exact_q ? exact_q : cor_z;
      end
      S_MGL: acc_q <= 64'(mg_lo) + MAG_HALF;
      S_MGH: mag_q <= mg_sum[20 +: CW];
      S_DSL: acc_q <= 64'(ds_lo) + DIST_HALF;
      S_DSH: begin
        acc_q <= acc_q + (64'(ds_hi) << MSPLIT);
      end
      S_DSAT: rem_q <= acc_q;
      S_DQL:  acc_q <= 64'(dq_lo);
      S_DQH:  quo_q <= dq_sum[70:45];
      S_ASET: begin
        neg_q <= av[ZW];
        rem_q <= 64'(av_mag);
      end
      S_ADIV: whole_q <= neg_q ? -$signed(wq) : $signed(wq);
      S_AFIX: rem_q <= {52'd0, anum};
      default: ;
    endcase
  end

  assign res_o.home_valid = home_set_q;
  assign res_o.dist_m     = dist_q;
  assign res_o.arrow      = arrow_q;
  assign res_o.alt        = home_set_q ? home_alt_q : '0;

endmodule
`default_nettype wire

### hdl/home_distance_bearing_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// home_distance_bearing_tracker_unit
// Latches a GPS home fix and returns distance and a 16-way return arrow.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  request  | push / full        | kind, fix_type, lat_e7, lon_e7, alt_cm,
//           |                    | heading_deg
//  result   | empty / pop        | home_valid, home_distance_m, home_arrow,
//           |                    | home_alt_out
//
//  One result per request, in order. Clear and latch requests skip the
//  computation; a tracking request makes two 24-step passes of the shared
//  CORDIC unit plus short multiply steps for distance, whole degrees and
//  arrow, and skips the distance divide steps when the distance saturates.
//  A two-entry request queue lets the front keep accepting while the back
//  works; a one-entry result register lets the back finish while the
//  consumer stalls. Reset clears home, queues and the result register.
// ----------------------------------------------------------------------------
module home_distance_bearing_tracker_unit import hdbt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               kind_i,
  input  logic [2:0]         fix_type_i,
  input  logic signed [30:0] lat_e7_i,
  input  logic signed [31:0] lon_e7_i,
  input  logic signed [27:0] alt_cm_i,
  input  logic [8:0]         heading_deg_i,
  output logic               empty,
  input  logic               pop,
  output logic               home_valid_o,
  output logic [25:0]        home_distance_m_o,
  output logic [4:0]         home_arrow_o,
  output logic signed [27:0] home_alt_out_o
);

  item_t   item;
  logic    item_valid, item_take;
  result_t res, out_q;
  logic    res_valid, res_ready, out_valid_q, pop_ok;

  // front: decode and queue requests
  hdbt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind_i),
    .fix_type_i    (fix_type_i),
    .lat_e7_i      (lat_e7_i),
    .lon_e7_i      (lon_e7_i),
    .alt_cm_i      (alt_cm_i),
    .heading_deg_i (heading_deg_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_take_i   (item_take)
  );

  // back: home state and the distance / bearing sequencer
  hdbt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  // result register: refills in the same cycle the old result is popped
  assign pop_ok    = pop && out_valid_q;
  assign res_ready = !out_valid_q || pop_ok;
  assign empty     = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign home_valid_o      = out_q.home_valid;
  assign home_distance_m_o = out_q.dist_m;
  assign home_arrow_o      = out_q.arrow;
  assign home_alt_out_o    = out_q.alt;

endmodule
`default_nettype wire
